### design/linear_interp_resampler_top_assert.svh
// Assertion macros used by the resampler top level.
`ifndef LINEAR_INTERP_RESAMPLER_TOP_ASSERT_SVH
`define LINEAR_INTERP_RESAMPLER_TOP_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define LINR_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its antecedent.
`define LINR_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

### design/linr_pkg.sv
package linr_pkg;

	localparam int SAMPLE_W      = 16;
	localparam int RATE_W        = 18;
	localparam int PHASE_W       = RATE_W + 1;
	localparam int DIFF_W        = SAMPLE_W + 1;
	localparam int ACC_W         = 36;
	localparam int MAG_W         = 34;
	localparam int NUM_W         = MAG_W + 1;
	localparam int QUO_W         = SAMPLE_W + 1;
	localparam int REM_W         = RATE_W + 2;
	localparam int CNT_W         = 5;
	localparam int MAX_RESULTS   = 16;
	localparam int MAX_RATIO_DEF = 8;
	localparam int CFG_IDX_W     = 2;

	localparam logic [CFG_IDX_W-1:0] REG_INPUT_RATE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_RATE = 2'd1;

	localparam logic [RATE_W-1:0] RESET_INPUT_RATE  = 18'd16000;
	localparam logic [RATE_W-1:0] RESET_OUTPUT_RATE = 18'd44100;

	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sd32767;
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = -16'sd32768;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample_in;
		logic                       end_of_stream;
	} linr_in_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample_out;
		logic                       last_of_run;
		logic                       stream_done;
	} linr_out_t;

	// Operands handed to the interpolation unit when it starts.
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] a;
		logic signed [SAMPLE_W-1:0] b;
		logic [RATE_W-1:0]          r;
		logic [RATE_W-1:0]          den;
	} linr_job_t;

	// Status returned by the interpolation unit.
	typedef struct packed {
		logic                       done;
		logic signed [SAMPLE_W-1:0] value;
	} linr_stat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ICHK,
		ST_IWAIT,
		ST_POST,
		ST_TCHK,
		ST_FIN
	} linr_state_t;

	typedef enum logic [2:0] {
		U_IDLE,
		U_MUL,
		U_ABS,
		U_LOAD,
		U_DIV,
		U_SAT,
		U_DONE
	} linr_unit_state_t;

endpackage

### design/linr_interp.sv
// Bit-serial interpolation unit: a + (b - a) * r / den, rounded half away
// from zero. A shift-add multiply consumes one bit of r and den per cycle,
// then a restoring divider produces one quotient bit per cycle.
module linr_interp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  linr_pkg::linr_job_t  job,
	output linr_pkg::linr_stat_t stat
);

	linr_pkg::linr_unit_state_t st_q;
	linr_pkg::linr_unit_state_t st_nxt;

	logic [linr_pkg::CNT_W-1:0]            cnt_q;
	logic signed [linr_pkg::SAMPLE_W-1:0]  a_q;
	logic signed [linr_pkg::DIFF_W-1:0]    d_q;
	logic [linr_pkg::RATE_W-1:0]           rsh_q;
	logic [linr_pkg::RATE_W-1:0]           dsh_q;
	logic [linr_pkg::RATE_W-1:0]           den_q;
	logic signed [linr_pkg::ACC_W-1:0]     acc_q;
	logic                                  neg_q;
	logic [linr_pkg::REM_W-1:0]            rem_q;
	logic [linr_pkg::QUO_W-1:0]            nlo_q;
	logic [linr_pkg::QUO_W-1:0]            quo_q;
	logic signed [linr_pkg::SAMPLE_W-1:0]  res_q;

	logic signed [linr_pkg::ACC_W-1:0] mul_sum;
	logic [linr_pkg::NUM_W-1:0]        num;
	logic [linr_pkg::REM_W-1:0]        trial;
	logic [linr_pkg::REM_W-1:0]        divisor;
	logic                              ge;
	logic [linr_pkg::QUO_W-1:0]        quo_neg;
	logic                              cnt_zero;

	assign cnt_zero = (cnt_q == '0);

	always_comb begin
		mul_sum = (acc_q <<< 1)
			+ (dsh_q[linr_pkg::RATE_W-1] ? linr_pkg::ACC_W'(a_q) : '0)
			+ (rsh_q[linr_pkg::RATE_W-1] ? linr_pkg::ACC_W'(d_q) : '0);
		num     = {acc_q[linr_pkg::MAG_W-1:0], 1'b0}
			+ {{(linr_pkg::NUM_W - linr_pkg::RATE_W){1'b0}}, den_q};
		trial   = {rem_q[linr_pkg::REM_W-2:0], nlo_q[linr_pkg::QUO_W-1]};
		divisor = {1'b0, den_q, 1'b0};
		ge      = (trial >= divisor);
		quo_neg = '0 - quo_q;
	end

	// Next state.
	always_comb begin
		st_nxt = st_q;
		case (st_q)
			linr_pkg::U_IDLE, linr_pkg::U_DONE: begin
				if (start) begin
					st_nxt = linr_pkg::U_MUL;
				end
			end
			linr_pkg::U_MUL: begin
				if (cnt_zero) begin
					st_nxt = linr_pkg::U_ABS;
				end
			end
			linr_pkg::U_ABS:  st_nxt = linr_pkg::U_LOAD;
			linr_pkg::U_LOAD: st_nxt = linr_pkg::U_DIV;
			linr_pkg::U_DIV: begin
				if (cnt_zero) begin
					st_nxt = linr_pkg::U_SAT;
				end
			end
			linr_pkg::U_SAT:  st_nxt = linr_pkg::U_DONE;
			default:          st_nxt = linr_pkg::U_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		stat.done  = (st_q == linr_pkg::U_DONE);
		stat.value = res_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= linr_pkg::U_IDLE;
			cnt_q <= '0;
		end else begin
			st_q <= st_nxt;
			case (st_q)
				linr_pkg::U_IDLE, linr_pkg::U_DONE: begin
					if (start) begin
						cnt_q <= linr_pkg::CNT_W'(linr_pkg::RATE_W - 1);
					end
				end
				linr_pkg::U_MUL, linr_pkg::U_DIV: begin
					cnt_q <= cnt_q - 1'b1;
				end
				linr_pkg::U_LOAD: begin
					cnt_q <= linr_pkg::CNT_W'(linr_pkg::QUO_W - 1);
				end
				default: begin
					cnt_q <= cnt_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			linr_pkg::U_IDLE, linr_pkg::U_DONE: begin
				if (start) begin
					a_q   <= job.a;
					d_q   <= linr_pkg::DIFF_W'(job.b) - linr_pkg::DIFF_W'(job.a);
					rsh_q <= job.r;
					dsh_q <= job.den;
					den_q <= job.den;
					acc_q <= '0;
				end
			end
			linr_pkg::U_MUL: begin
				acc_q <= mul_sum;
				rsh_q <= rsh_q << 1;
				dsh_q <= dsh_q << 1;
			end
			linr_pkg::U_ABS: begin
				neg_q <= acc_q[linr_pkg::ACC_W-1];
				acc_q <= acc_q[linr_pkg::ACC_W-1] ? -acc_q : acc_q;
			end
			linr_pkg::U_LOAD: begin
				rem_q <= linr_pkg::REM_W'(num[linr_pkg::NUM_W-1:linr_pkg::QUO_W]);
				nlo_q <= num[linr_pkg::QUO_W-1:0];
				quo_q <= '0;
			end
			linr_pkg::U_DIV: begin
				rem_q <= ge ? (trial - divisor) : trial;
				nlo_q <= nlo_q << 1;
				quo_q <= {quo_q[linr_pkg::QUO_W-2:0], ge};
			end
			linr_pkg::U_SAT: begin
				if (neg_q) begin
					if (quo_q > linr_pkg::QUO_W'(32768)) begin
						res_q <= linr_pkg::SAMPLE_MIN;
					end else begin
						res_q <= quo_neg[linr_pkg::SAMPLE_W-1:0];
					end
				end else begin
					if (quo_q > linr_pkg::QUO_W'(32767)) begin
						res_q <= linr_pkg::SAMPLE_MAX;
					end else begin
						res_q <= quo_q[linr_pkg::SAMPLE_W-1:0];
					end
				end
			end
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

endmodule

### design/linear_interp_resampler_top.sv
// Linear-interpolation sample-rate converter for mono signed 16-bit audio.
// The src channel carries one input sample and its end-of-stream flag per
// transaction; the res channel carries one output sample per transaction,
// flagged as the last one caused by its input and as the last of the stream.
// The cfg channel writes the incoming rate (index 0) and the outgoing rate
// (index 1); a write of zero stores one, the outgoing rate is clamped to
// MAX_RATIO times the input rate, and each such write starts a new stream.
// One input is processed at a time. Each interpolated output runs through
// the bit-serial unit (18 multiply steps, 17 divide steps and the ABS,
// LOAD and SAT states around them); copies and equal-rate items skip it.
// The first result of an item leaves one result later than it is computed,
// because each result is held until the block knows whether it is the last.
// Reset sets the rates to 16000 and 44100 Hz and clears the stream state.
// When the receiver stalls, one result waits in the output register and one
// in the holding register; the block then stops until res_ready returns.
// The input is taken again as soon as the last result of an item has moved
// into the output register, even while that result is still waiting.
`include "linear_interp_resampler_top_assert.svh"

module linear_interp_resampler_top #(
	parameter int MAX_RATIO = linr_pkg::MAX_RATIO_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           src_valid,
	output logic                           src_ready,
	input  linr_pkg::linr_in_t             src_data,
	output logic                           res_valid,
	input  logic                           res_ready,
	output linr_pkg::linr_out_t            res_data,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [linr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [linr_pkg::RATE_W-1:0]    cfg_data
);

	localparam int CAP_W = linr_pkg::RATE_W + $clog2(MAX_RATIO + 1);

	// Rate registers, always nonzero and clamped.
	logic [linr_pkg::RATE_W-1:0] in_rate_q;
	logic [linr_pkg::RATE_W-1:0] out_rate_q;

	// Stream state.
	logic signed [linr_pkg::SAMPLE_W-1:0] prev_q;
	logic                                 have_q;
	logic [linr_pkg::PHASE_W-1:0]         r_q;

	// Current item and result bookkeeping.
	logic signed [linr_pkg::SAMPLE_W-1:0] cur_q;
	logic                                 eos_q;
	logic [linr_pkg::CNT_W-1:0]           n_q;
	logic signed [linr_pkg::SAMPLE_W-1:0] hold_q;
	logic                                 hold_v_q;
	logic                                 res_valid_q;
	linr_pkg::linr_out_t                  res_q;

	linr_pkg::linr_state_t state_q;
	linr_pkg::linr_state_t state_nxt;

	linr_pkg::linr_job_t  job;
	linr_pkg::linr_stat_t ustat;

	// Configuration write decode.
	logic [linr_pkg::RATE_W-1:0] cfg_val;
	logic [linr_pkg::RATE_W-1:0] new_in;
	logic [linr_pkg::RATE_W-1:0] new_out;
	logic [CAP_W-1:0]            new_cap;
	logic [CAP_W-1:0]            cur_cap;
	logic                        cfg_hit;

	// Control decode.
	logic                                 accept;
	logic                                 equal_rates;
	logic                                 out_free;
	logic                                 place_ok;
	logic                                 more;
	logic                                 unit_start;
	logic                                 take;
	logic signed [linr_pkg::SAMPLE_W-1:0] take_val;
	logic                                 r_fix;
	logic                                 prev_upd;
	logic                                 fin_go;
	logic                                 push_mid;
	logic                                 push_final;

	always_comb begin
		cfg_val = (cfg_data == '0) ? linr_pkg::RATE_W'(1) : cfg_data;
		new_in  = (cfg_index == linr_pkg::REG_INPUT_RATE) ? cfg_val : in_rate_q;
		new_out = (cfg_index == linr_pkg::REG_OUTPUT_RATE) ? cfg_val : out_rate_q;
		new_cap = CAP_W'(new_in) * CAP_W'(MAX_RATIO);
		cur_cap = CAP_W'(in_rate_q) * CAP_W'(MAX_RATIO);
		cfg_hit = cfg_valid && (cfg_index == linr_pkg::REG_INPUT_RATE
			|| cfg_index == linr_pkg::REG_OUTPUT_RATE);
	end

	assign cfg_ready   = 1'b1;
	assign equal_rates = (in_rate_q == out_rate_q);
	assign out_free    = !res_valid_q || res_ready;
	assign place_ok    = !hold_v_q || out_free;
	assign more        = (r_q < linr_pkg::PHASE_W'(out_rate_q))
		&& (n_q < linr_pkg::CNT_W'(linr_pkg::MAX_RESULTS));

	// Next state.
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			linr_pkg::ST_IDLE: begin
				if (src_valid) begin
					if (equal_rates) begin
						state_nxt = linr_pkg::ST_FIN;
					end else if (have_q) begin
						state_nxt = linr_pkg::ST_ICHK;
					end else begin
						state_nxt = linr_pkg::ST_POST;
					end
				end
			end
			linr_pkg::ST_ICHK: begin
				state_nxt = more ? linr_pkg::ST_IWAIT : linr_pkg::ST_POST;
			end
			linr_pkg::ST_IWAIT: begin
				if (ustat.done && place_ok) begin
					state_nxt = linr_pkg::ST_ICHK;
				end
			end
			linr_pkg::ST_POST: begin
				state_nxt = eos_q ? linr_pkg::ST_TCHK : linr_pkg::ST_FIN;
			end
			linr_pkg::ST_TCHK: begin
				if (!more) begin
					state_nxt = linr_pkg::ST_FIN;
				end
			end
			linr_pkg::ST_FIN: begin
				if (place_ok) begin
					state_nxt = linr_pkg::ST_IDLE;
				end
			end
			default: state_nxt = linr_pkg::ST_IDLE;
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		src_ready  = (state_q == linr_pkg::ST_IDLE);
		accept     = src_ready && src_valid;
		unit_start = (state_q == linr_pkg::ST_ICHK) && more;
		r_fix      = (state_q == linr_pkg::ST_ICHK) && !more;
		prev_upd   = (state_q == linr_pkg::ST_POST);
		fin_go     = (state_q == linr_pkg::ST_FIN) && place_ok;
		take       = 1'b0;
		take_val   = cur_q;
		case (state_q)
			linr_pkg::ST_IWAIT: begin
				take     = ustat.done && place_ok;
				take_val = ustat.value;
			end
			linr_pkg::ST_TCHK: begin
				take     = more && place_ok;
				take_val = cur_q;
			end
			default: begin
				take = 1'b0;
			end
		endcase
		push_mid   = take && hold_v_q;
		push_final = fin_go && hold_v_q;
	end

	always_comb begin
		job.a   = prev_q;
		job.b   = cur_q;
		job.r   = r_q[linr_pkg::RATE_W-1:0];
		job.den = out_rate_q;
	end

	linr_interp u_interp (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (unit_start),
		.job    (job),
		.stat   (ustat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= linr_pkg::ST_IDLE;
			in_rate_q   <= linr_pkg::RESET_INPUT_RATE;
			out_rate_q  <= linr_pkg::RESET_OUTPUT_RATE;
			prev_q      <= '0;
			have_q      <= 1'b0;
			r_q         <= '0;
			n_q         <= '0;
			hold_v_q    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;

			if (cfg_hit) begin
				in_rate_q  <= new_in;
				out_rate_q <= (CAP_W'(new_out) > new_cap)
					? new_cap[linr_pkg::RATE_W-1:0] : new_out;
				prev_q     <= '0;
				have_q     <= 1'b0;
				r_q        <= '0;
			end

			if (accept) begin
				n_q <= '0;
				if (equal_rates) begin
					hold_v_q <= 1'b1;
					if (!src_data.end_of_stream) begin
						prev_q <= src_data.sample_in;
						have_q <= 1'b1;
					end
				end
			end

			if (take) begin
				hold_v_q <= 1'b1;
				n_q      <= n_q + 1'b1;
				r_q      <= r_q + linr_pkg::PHASE_W'(in_rate_q);
			end

			// The left sample moves on: drop one output period from the phase,
			// or restart at zero when the result cap cut the run short.
			if (r_fix) begin
				r_q <= (r_q >= linr_pkg::PHASE_W'(out_rate_q))
					? r_q - linr_pkg::PHASE_W'(out_rate_q) : '0;
			end

			if (prev_upd) begin
				prev_q <= cur_q;
				have_q <= 1'b1;
			end

			if (fin_go) begin
				hold_v_q <= 1'b0;
				if (eos_q) begin
					prev_q <= '0;
					have_q <= 1'b0;
					r_q    <= '0;
				end
			end

			if (push_mid || push_final) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cur_q <= src_data.sample_in;
			eos_q <= src_data.end_of_stream;
			if (equal_rates) begin
				hold_q <= src_data.sample_in;
			end
		end
		if (take) begin
			hold_q <= take_val;
		end
		if (push_mid) begin
			res_q.sample_out  <= hold_q;
			res_q.last_of_run <= 1'b0;
			res_q.stream_done <= 1'b0;
		end else if (push_final) begin
			res_q.sample_out  <= hold_q;
			res_q.last_of_run <= 1'b1;
			res_q.stream_done <= eos_q;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	// The rates stay nonzero and within the ratio limit.
	`LINR_ASSERT_ALWAYS(rate_range_a, clk, arst_n, (in_rate_q != '0) && (out_rate_q != '0) && (CAP_W'(out_rate_q) <= cur_cap), "rate registers out of range")
	// The end of a stream always closes the run of its input.
	`LINR_ASSERT_IMPLY(done_last_a, clk, arst_n, res_valid && res_data.stream_done, res_data.last_of_run, "stream_done without last_of_run")
	// Between items nothing is held back and the phase is below one input period.
	`LINR_ASSERT_IMPLY(idle_clean_a, clk, arst_n, src_ready, !hold_v_q && (r_q < linr_pkg::PHASE_W'(in_rate_q)), "idle with pending result or bad phase")

endmodule

### tb/sv/linear_interp_resampler_top_tb.sv
module linear_interp_resampler_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// The block's ratio limit. The DUT is built with the same value that the
	// predictor uses for its clamp.
	localparam int RATIO = linr_pkg::MAX_RATIO_DEF;

	// An item that causes no result may still be in flight when the last
	// expected result arrives. This pause comfortably covers such an item
	// before a register write or the end.
	localparam int SETTLE_CYCLES = 64;

	// The watchdog ends the run after this many cycles without any accepted
	// transaction. The slowest correct gap is one interpolated result behind
	// a receiver hold, or a settle pause, so this is several times the worst
	// case.
	localparam int WATCHDOG_LIMIT = 4000;

	// Number of random input samples to send after the directed tests.
	localparam int RANDOM_SAMPLES = 225;

	// Receiver behavior, chosen again at the end of each segment.
	typedef enum int {
		RX_OPEN,
		RX_RANDOM,
		RX_SPARSE,
		RX_HOLD
	} rx_mode_t;

	// Sample content of one random stream.
	typedef enum int {
		WAVE_NOISE,
		WAVE_QUIET,
		WAVE_RAILS,
		WAVE_RAMP
	} wave_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                src_valid = 1'b0;
	logic                src_ready;
	linr_pkg::linr_in_t  src_data = '0;
	logic                res_valid;
	logic                res_ready = 1'b0;
	linr_pkg::linr_out_t res_data;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [linr_pkg::CFG_IDX_W-1:0] cfg_index = linr_pkg::REG_INPUT_RATE;
	logic [linr_pkg::RATE_W-1:0]    cfg_data = '0;

	linear_interp_resampler_top #(
		.MAX_RATIO(RATIO)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.src_valid(src_valid),
		.src_ready(src_ready),
		.src_data (src_data),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res_data (res_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// Predicted state of the converter. The rates start at their reset values
	// and the stream state starts cleared, just like the block after reset.
	int unsigned        pred_in_rate = linr_pkg::RESET_INPUT_RATE;
	int unsigned        pred_out_rate = linr_pkg::RESET_OUTPUT_RATE;
	logic signed [15:0] pred_prev_sample = '0;
	bit                 pred_have_prev = 1'b0;
	int unsigned        pred_residual = 0;

	// Output samples that the block still owes, oldest first.
	linr_pkg::linr_out_t expected_samples[$];

	int mismatch_count = 0;
	int result_count = 0;
	int quiet_cycles = 0;
	int burst_left = 0;
	int stall_left = 0;
	rx_mode_t stall_mode = RX_OPEN;
	linr_pkg::linr_out_t want_sample;

	int unsigned audio_rates[9] = '{8000, 11025, 16000, 22050, 32000, 44100, 48000, 96000,
		192000};

	initial begin
		forever #4 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	function automatic void clear_stream_state();
		pred_prev_sample = '0;
		pred_have_prev = 1'b0;
		pred_residual = 0;
	endfunction

	// A rate write stores one for zero, clamps the output rate to RATIO
	// times the input rate and starts a new stream. Unknown indexes are
	// ignored entirely, stream state included.
	function automatic void apply_rate_write(logic [linr_pkg::CFG_IDX_W-1:0] index,
			logic [linr_pkg::RATE_W-1:0] value);
		int unsigned rate;
		rate = value;
		if (rate == 0) begin
			rate = 1;
		end
		if (index == linr_pkg::REG_INPUT_RATE) begin
			pred_in_rate = rate;
		end else if (index == linr_pkg::REG_OUTPUT_RATE) begin
			pred_out_rate = rate;
		end else begin
			return;
		end
		if (pred_out_rate > RATIO * pred_in_rate) begin
			pred_out_rate = RATIO * pred_in_rate;
		end
		clear_stream_state();
	endfunction

	// Exact a + (b - a) * r / den, rounded half away from zero and saturated.
	function automatic logic signed [15:0] interp_round(longint a, longint b, longint r,
			longint den);
		longint num;
		longint q;
		num = a * den + (b - a) * r;
		if (num >= 0) begin
			q = (2 * num + den) / (2 * den);
		end else begin
			q = -((2 * (-num) + den) / (2 * den));
		end
		if (q > 32767) begin
			q = 32767;
		end
		if (q < -32768) begin
			q = -32768;
		end
		return q[15:0];
	endfunction

	// Works out every output sample that one accepted input causes and queues
	// them in order. The last one carries last_of_run, and on the final input
	// of a stream it also carries stream_done.
	task automatic predict_resample(input linr_pkg::linr_in_t item);
		linr_pkg::linr_out_t run[$];
		linr_pkg::linr_out_t one;
		logic signed [15:0] s;
		bit eos;
		s = item.sample_in;
		eos = item.end_of_stream;
		one = '0;
		if (pred_in_rate == pred_out_rate) begin
			// Equal rates: the sample passes straight through.
			one.sample_out = s;
			one.last_of_run = 1'b1;
			one.stream_done = eos;
			expected_samples = {expected_samples, one};
			if (eos) begin
				clear_stream_state();
			end else begin
				pred_prev_sample = s;
				pred_have_prev = 1'b1;
			end
			return;
		end
		if (pred_have_prev) begin
			// Every output whose left sample is the previous one is due now.
			while (pred_residual < pred_out_rate
					&& run.size() < linr_pkg::MAX_RESULTS) begin
				one.sample_out = interp_round(pred_prev_sample, s, pred_residual,
					pred_out_rate);
				run = {run, one};
				pred_residual += pred_in_rate;
			end
			if (pred_residual >= pred_out_rate) begin
				pred_residual -= pred_out_rate;
			end else begin
				pred_residual = 0;
			end
		end
		pred_prev_sample = s;
		pred_have_prev = 1'b1;
		if (eos) begin
			// The tail of the stream repeats the final sample.
			while (pred_residual < pred_out_rate
					&& run.size() < linr_pkg::MAX_RESULTS) begin
				one.sample_out = s;
				run = {run, one};
				pred_residual += pred_in_rate;
			end
			clear_stream_state();
		end
		if (run.size() > 0) begin
			one = run[run.size() - 1];
			one.last_of_run = 1'b1;
			one.stream_done = eos;
			run[run.size() - 1] = one;
		end
		expected_samples = {expected_samples, run};
	endtask

	// ------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------

	// Sends one input sample. The sender works in bursts: while a burst lasts,
	// valid stays high from one transaction to the next; between bursts it
	// drops for a random number of cycles. Called and returning at a falling
	// edge, so valid and data only ever change there.
	task automatic send_sample(input logic signed [15:0] value, input logic eos);
		linr_pkg::linr_in_t item;
		int gap;
		item.sample_in = value;
		item.end_of_stream = eos;
		if (burst_left == 0) begin
			gap = $urandom_range(12, 1);
			src_valid <= 1'b0;
			repeat (gap) @(negedge clk);
			burst_left = ($urandom_range(3, 0) == 0) ? 100 : $urandom_range(20, 1);
		end
		src_valid <= 1'b1;
		src_data <= item;
		do @(posedge clk); while (!src_ready);
		predict_resample(item);
		burst_left--;
		@(negedge clk);
	endtask

	// Stops the sender and waits until the block has delivered everything it
	// owes, then lets it settle. Afterwards the block is idle.
	task automatic drain_results();
		src_valid <= 1'b0;
		burst_left = 0;
		while (expected_samples.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Writes one rate register. Valid drops after the write and stays low until
	// it returns, so back-to-back calls never raise and lower it in one step.
	task automatic write_rate(input logic [linr_pkg::CFG_IDX_W-1:0] index,
			input logic [linr_pkg::RATE_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		apply_rate_write(index, value);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// Receiver: segments of random length, each with its own pattern. An open
	// segment never stalls, a random one stalls about half the time, a sparse
	// one is ready only about one time in eight, and a hold stalls throughout.
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = rx_mode_t'($urandom_range(3, 0));
			stall_left = (stall_mode == RX_HOLD) ? $urandom_range(150, 20) :
				$urandom_range(300, 20);
		end
		stall_left--;
		case (stall_mode)
			RX_OPEN: begin
				res_ready <= 1'b1;
			end
			RX_RANDOM: begin
				res_ready <= 1'($urandom_range(1, 0));
			end
			RX_SPARSE: begin
				res_ready <= ($urandom_range(7, 0) == 0);
			end
			default: begin
				res_ready <= 1'b0;
			end
		endcase
	end

	// ------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------

	task automatic report_mismatch(input string what);
		$display("[%0t] result %0d: %s", $realtime, result_count, what);
		mismatch_count++;
	endtask

	// Every accepted result is matched against the oldest expectation. All
	// signals are read right at the rising edge, before the block updates.
	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready) begin
			if (expected_samples.size() == 0) begin
				report_mismatch($sformatf("unexpected result, sample_out %0d",
					$signed(res_data.sample_out)));
			end else begin
				want_sample = expected_samples.pop_front();
				if (res_data.sample_out !== want_sample.sample_out) begin
					report_mismatch($sformatf("sample_out %0d, expected %0d",
						$signed(res_data.sample_out), $signed(want_sample.sample_out)));
				end
				if (res_data.last_of_run !== want_sample.last_of_run) begin
					report_mismatch($sformatf("last_of_run %b, expected %b",
						res_data.last_of_run, want_sample.last_of_run));
				end
				if (res_data.stream_done !== want_sample.stream_done) begin
					report_mismatch($sformatf("stream_done %b, expected %b",
						res_data.stream_done, want_sample.stream_done));
				end
			end
			result_count++;
		end
	end

	// Watchdog: counts cycles in which no channel moves a transaction.
	always @(posedge clk) begin
		if ((src_valid && src_ready) || (res_valid && res_ready) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Upsampling at the reset rates, with the sample extremes next to each
	// other so the interpolation spans the full range.
	task automatic test_reset_rates();
		send_sample(16'sd0, 1'b0);
		send_sample(linr_pkg::SAMPLE_MAX, 1'b0);
		send_sample(linr_pkg::SAMPLE_MIN, 1'b0);
		send_sample(linr_pkg::SAMPLE_MAX, 1'b0);
		send_sample(-16'sd1, 1'b0);
		send_sample(16'sd100, 1'b1);
	endtask

	// Equal rates pass samples straight through, including a stream that is
	// only one sample long.
	task automatic test_equal_rates();
		drain_results();
		write_rate(linr_pkg::REG_INPUT_RATE, 18'd48000);
		write_rate(linr_pkg::REG_OUTPUT_RATE, 18'd48000);
		send_sample(linr_pkg::SAMPLE_MAX, 1'b0);
		send_sample(linr_pkg::SAMPLE_MIN, 1'b0);
		send_sample(16'sd1, 1'b1);
		send_sample(-16'sd2, 1'b1);
	endtask

	// Register corner cases: zero is stored as one, an output rate above the
	// ratio limit is clamped, lowering the input rate clamps the output rate
	// again, and writes to unused indexes change nothing.
	task automatic test_rate_limits();
		drain_results();
		write_rate(linr_pkg::REG_INPUT_RATE, 18'd0);
		write_rate(linr_pkg::REG_OUTPUT_RATE, 18'd0);
		send_sample(16'sd5, 1'b1);
		drain_results();
		// The largest register value is clamped to eight times one hertz, so
		// the final sample yields the most results an item can cause.
		write_rate(linr_pkg::REG_OUTPUT_RATE, 18'h3FFFF);
		send_sample(linr_pkg::SAMPLE_MIN, 1'b0);
		send_sample(linr_pkg::SAMPLE_MAX, 1'b0);
		send_sample(16'sd0, 1'b1);
		drain_results();
		write_rate(linr_pkg::REG_INPUT_RATE, 18'd3);
		write_rate(linr_pkg::REG_OUTPUT_RATE, 18'd24);
		write_rate(linr_pkg::REG_INPUT_RATE, 18'd2);
		write_rate(2'd2, 18'd1234);
		write_rate(2'd3, 18'h3FFFF);
		send_sample(16'sd100, 1'b0);
		send_sample(-16'sd100, 1'b1);
	endtask

	// Downsampling by six skips input pairs, and here the final sample of the
	// first stream produces nothing, so no result marks that stream as done.
	// A single-sample stream then gets exactly one copy.
	task automatic test_downsampling();
		drain_results();
		write_rate(linr_pkg::REG_INPUT_RATE, 18'd48000);
		write_rate(linr_pkg::REG_OUTPUT_RATE, 18'd8000);
		send_sample(16'sd1000, 1'b0);
		send_sample(-16'sd1000, 1'b0);
		send_sample(16'sd7, 1'b1);
		send_sample(-16'sd32000, 1'b1);
	endtask

	// A register write in the middle of a stream discards it; the next
	// sample starts a fresh stream with no previous sample.
	task automatic test_stream_restart();
		drain_results();
		write_rate(linr_pkg::REG_INPUT_RATE, 18'd44100);
		write_rate(linr_pkg::REG_OUTPUT_RATE, 18'd48000);
		send_sample(16'sd20000, 1'b0);
		send_sample(-16'sd20000, 1'b0);
		send_sample(16'sd12345, 1'b0);
		drain_results();
		write_rate(linr_pkg::REG_OUTPUT_RATE, 18'd48000);
		send_sample(-16'sd300, 1'b0);
		send_sample(16'sd300, 1'b1);
	endtask

	function automatic logic signed [15:0] pick_sample(wave_t wave, int k);
		int v;
		case (wave)
			WAVE_NOISE: begin
				v = $urandom;
			end
			WAVE_QUIET: begin
				v = int'($urandom_range(400, 0)) - 200;
			end
			WAVE_RAILS: begin
				v = (k % 2 == 0) ? 32767 : -32768;
			end
			default: begin
				v = k * 2900 - 20000;
			end
		endcase
		return v[15:0];
	endfunction

	// Random phases: each one picks a pair of rates, then sends a few streams
	// of random samples. Most streams end with an end-of-stream sample; the
	// others are left open and carry on into the next stream, or are cut off
	// by the next phase's register writes.
	task automatic test_random_streams();
		int sent;
		int stream_len;
		int ratio;
		int unsigned in_val;
		int unsigned out_val;
		longint scaled;
		bit out_first;
		wave_t wave;
		sent = 0;
		while (sent < RANDOM_SAMPLES) begin
			out_first = 1'b0;
			case ($urandom_range(5, 0))
				0, 1: begin
					in_val = audio_rates[$urandom_range(8, 0)];
					out_val = audio_rates[$urandom_range(8, 0)];
					out_first = 1'($urandom_range(1, 0));
				end
				2: begin
					in_val = $urandom_range(192000, 1);
					out_val = in_val;
				end
				3, 4: begin
					in_val = $urandom_range(192000, 1);
					ratio = $urandom_range(800, 12);
					scaled = (longint'(in_val) * ratio) / 100;
					out_val = (scaled > 192000) ? 192000 : int'(scaled);
					out_first = 1'($urandom_range(1, 0));
				end
				default: begin
					// The extremes of both registers.
					case ($urandom_range(3, 0))
						0: begin
							in_val = 1;
							out_val = 18'h3FFFF;
						end
						1: begin
							in_val = 192000;
							out_val = 1;
						end
						2: begin
							in_val = 192000;
							out_val = 192000;
						end
						default: begin
							in_val = 0;
							out_val = 0;
						end
					endcase
				end
			endcase
			drain_results();
			if (out_first) begin
				write_rate(linr_pkg::REG_OUTPUT_RATE, out_val[linr_pkg::RATE_W-1:0]);
				write_rate(linr_pkg::REG_INPUT_RATE, in_val[linr_pkg::RATE_W-1:0]);
			end else begin
				write_rate(linr_pkg::REG_INPUT_RATE, in_val[linr_pkg::RATE_W-1:0]);
				write_rate(linr_pkg::REG_OUTPUT_RATE, out_val[linr_pkg::RATE_W-1:0]);
			end
			repeat ($urandom_range(4, 1)) begin
				wave = wave_t'($urandom_range(3, 0));
				stream_len = ($urandom_range(7, 0) == 0) ? 30 : $urandom_range(12, 1);
				for (int k = 0; k < stream_len && sent < RANDOM_SAMPLES; k++) begin
					send_sample(pick_sample(wave, k),
						(k == stream_len - 1) && ($urandom_range(7, 0) != 0));
					sent++;
				end
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------

	// Reset is held low from the start and released at a falling edge; all
	// stimulus is applied on falling edges from then on.
	initial begin
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_reset_rates();
		test_equal_rates();
		test_rate_limits();
		test_downsampling();
		test_stream_restart();
		test_random_streams();
		// Wait for every owed result, then long enough for a stray extra
		// result to show up and be flagged.
		drain_results();
		if (mismatch_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
